// ----- rtl/core/vpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int MEM_UNITS = 1024;
    localparam int AW        = 10;   // address bits
    localparam int LW        = 11;   // length bits, holds MEM_UNITS
    localparam int SW        = 3;    // status bits

    localparam logic [SW-1:0] ST_OK         = 3'd0;
    localparam logic [SW-1:0] ST_NO_FIT     = 3'd1;
    localparam logic [SW-1:0] ST_NO_SEGMENT = 3'd2;
    localparam logic [SW-1:0] ST_FULL       = 3'd3;
    localparam logic [SW-1:0] ST_ZERO       = 3'd4;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_NEXT  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_ZERO  = 2'd2
    } t_kind;

    typedef struct packed {
        logic          op;
        logic [LW-1:0] alloc_size;
        logic [AW-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic [SW-1:0] status;
        logic [AW-1:0] block_address;
    } t_res;

    typedef struct packed {
        t_kind         kind;
        logic [LW-1:0] size;
        logic [AW-1:0] addr;
    } t_cmd;

endpackage

// ----- rtl/core/variable_partition_allocator_core.sv -----
`timescale 1ns / 1ps
// The time from accept to result is set by the walk of the segment table
// (one entry per cycle; next fit walks it twice).
// The back end serves one request at a time; a two-beat input queue and a
// result register decouple both sides.
// Reset: synchronous active low; table holds one free segment of all units,
// rover and fit mode cleared.
// ----------------------------------------------------------------------------
// variable_partition_allocator_core
// First/best/next-fit segment allocator with split and coalescing free.
// ----------------------------------------------------------------------------
module variable_partition_allocator_core import vpa_pkg::*; #(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request queue side
    input  logic       push,
    input  t_req       i_req,
    output logic       full,
    // result queue side
    output logic       empty,
    input  logic       pop,
    output t_res       o_res,
    // fit mode register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    logic       w_cmd_valid, w_cmd_pop;
    t_cmd       w_cmd;
    logic       w_res_valid, w_res_ready;
    t_res       w_res;

    logic [1:0] r_mode;
    logic       r_out_valid;
    t_res       r_out;

    // the mode register is always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FIRST;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // front: accepts and classifies request beats
    vpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_req       (i_req),
        .full        (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // back: walks and edits the segment table
    vpa_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // result register; back end may hand over a beat in the cycle it is popped
    assign w_res_ready = !r_out_valid || pop;
    assign empty       = !r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

endmodule

// ----- rtl/core/vpa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_front
// Accepts request beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module vpa_front import vpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    input  t_req i_req,
    output logic full,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    // two-entry queue
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    always_comb begin
        w_cmd.size = i_req.alloc_size;
        w_cmd.addr = i_req.free_address;
        if (i_req.op == OP_FREE) begin
            w_cmd.kind = K_FREE;
        end else if (i_req.alloc_size == '0) begin
            w_cmd.kind = K_ZERO;
        end else begin
            w_cmd.kind = K_ALLOC;
        end
    end

    assign full        = r_cnt[1];
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ----- rtl/core/vpa_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_back
// Segment table and the sequencer that walks it to allocate and free.
// ----------------------------------------------------------------------------
module vpa_back import vpa_pkg::*; #(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_mode,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_res_valid,
    output t_res       o_res,
    input  logic       i_res_ready
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RSCAN = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_PICK  = 9'b000001000,
        S_ROVER = 9'b000010000,
        S_FSCAN = 9'b000100000,
        S_FNEXT = 9'b001000000,
        S_FPREV = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    logic [AW-1:0] r_start [MAX_SEGMENTS];
    logic [LW-1:0] r_len   [MAX_SEGMENTS];
    logic          r_free  [MAX_SEGMENTS];

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_rover, n_rover;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_first, n_first;
    logic [IW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_slen, n_slen;
    logic [AW-1:0] r_sstart, n_sstart;
    logic          r_found, n_found;
    logic [LW-1:0] r_size, n_size;
    logic [AW-1:0] r_addr, n_addr;
    logic [1:0]    r_mode, n_mode;
    logic [SW-1:0] r_status, n_status;
    logic [AW-1:0] r_raddr, n_raddr;

    logic [AW-1:0] rd_start;
    logic [LW-1:0] rd_len;
    logic          rd_free;
    logic          w_fit;
    logic [CW-1:0] w_last;

    // table update controls
    logic          c_split;
    logic          c_rm;
    logic [IW-1:0] c_rm_idx;
    logic          c_wr;
    logic [IW-1:0] c_wr_idx;
    logic          c_wr_len_en;
    logic [LW-1:0] c_wr_len;
    logic          c_wr_free_en;
    logic          c_wr_free;
    logic [AW-1:0] w_split_start;
    logic [LW-1:0] w_split_len;

    assign rd_start = r_start[r_i[IW-1:0]];
    assign rd_len   = r_len[r_i[IW-1:0]];
    assign rd_free  = r_free[r_i[IW-1:0]];
    assign w_fit    = rd_free && (rd_len >= r_size);
    assign w_last   = r_count - 1'b1;

    assign w_split_start = AW'({1'b0, r_sstart} + r_size);
    assign w_split_len   = r_slen - r_size;

    assign o_res_valid         = (r_state == S_DONE);
    assign o_res.status        = r_status;
    assign o_res.block_address = r_raddr;
    assign o_cmd_pop           = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rover  = r_rover;
        n_i      = r_i;
        n_n      = r_n;
        n_first  = r_first;
        n_idx    = r_idx;
        n_slen   = r_slen;
        n_sstart = r_sstart;
        n_found  = r_found;
        n_size   = r_size;
        n_addr   = r_addr;
        n_mode   = r_mode;
        n_status = r_status;
        n_raddr  = r_raddr;

        c_split      = 1'b0;
        c_rm         = 1'b0;
        c_rm_idx     = '0;
        c_wr         = 1'b0;
        c_wr_idx     = '0;
        c_wr_len_en  = 1'b0;
        c_wr_len     = '0;
        c_wr_free_en = 1'b0;
        c_wr_free    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_size   = i_cmd.size;
                    n_addr   = i_cmd.addr;
                    n_mode   = i_mode;
                    n_raddr  = '0;
                    n_i      = '0;
                    n_first  = '0;
                    n_found  = 1'b0;
                    case (i_cmd.kind)
                        K_ZERO: begin
                            n_status = ST_ZERO;
                            n_state  = S_DONE;
                        end
                        K_FREE: begin
                            n_state = S_FSCAN;
                        end
                        default: begin
                            n_state = (i_mode == MODE_NEXT) ? S_RSCAN : S_SCAN;
                        end
                    endcase
                end
            end

            // find the last segment starting at or below the rover
            S_RSCAN: begin
                if (rd_start <= r_rover) begin
                    n_first = r_i;
                end
                if (r_i == w_last) begin
                    n_i     = (rd_start <= r_rover) ? r_i : r_first;
                    n_n     = '0;
                    n_state = S_SCAN;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end

            S_SCAN: begin
                if (r_mode == MODE_BEST) begin
                    if (w_fit && (!r_found || rd_len < r_slen)) begin
                        n_found  = 1'b1;
                        n_idx    = r_i[IW-1:0];
                        n_slen   = rd_len;
                        n_sstart = rd_start;
                    end
                    if (r_i == w_last) begin
                        if (n_found) begin
                            n_state = S_PICK;
                        end else begin
                            n_status = ST_NO_FIT;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else if (r_mode == MODE_NEXT) begin
                    if (w_fit) begin
                        n_idx    = r_i[IW-1:0];
                        n_slen   = rd_len;
                        n_sstart = rd_start;
                        n_state  = S_PICK;
                    end else if (r_n == w_last) begin
                        n_status = ST_NO_FIT;
                        n_state  = S_DONE;
                    end else begin
                        n_n = r_n + 1'b1;
                        n_i = (r_i == w_last) ? '0 : r_i + 1'b1;
                    end
                end else begin
                    if (w_fit) begin
                        n_idx    = r_i[IW-1:0];
                        n_slen   = rd_len;
                        n_sstart = rd_start;
                        n_state  = S_PICK;
                    end else if (r_i == w_last) begin
                        n_status = ST_NO_FIT;
                        n_state  = S_DONE;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end

            S_PICK: begin
                if (r_slen > r_size) begin
                    if (r_count == CMAX) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        c_split  = 1'b1;
                        n_count  = r_count + 1'b1;
                        n_status = ST_OK;
                        n_raddr  = r_sstart;
                        if (r_mode == MODE_NEXT) begin
                            n_rover = w_split_start;
                        end
                        n_state = S_DONE;
                    end
                end else begin
                    c_wr         = 1'b1;
                    c_wr_idx     = r_idx;
                    c_wr_free_en = 1'b1;
                    c_wr_free    = 1'b0;
                    n_status     = ST_OK;
                    n_raddr      = r_sstart;
                    if (r_mode == MODE_NEXT) begin
                        n_i     = CW'({1'b0, r_idx} + 1'b1);
                        n_state = S_ROVER;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            S_ROVER: begin
                n_rover = (r_i < r_count) ? rd_start : '0;
                n_state = S_DONE;
            end

            S_FSCAN: begin
                if (rd_start == r_addr) begin
                    n_idx        = r_i[IW-1:0];
                    n_slen       = rd_len;
                    c_wr         = 1'b1;
                    c_wr_idx     = r_i[IW-1:0];
                    c_wr_free_en = 1'b1;
                    c_wr_free    = 1'b1;
                    n_i          = r_i + 1'b1;
                    n_state      = S_FNEXT;
                end else if (r_i == w_last) begin
                    n_status = ST_NO_SEGMENT;
                    n_state  = S_DONE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end

            // merge with the following segment
            S_FNEXT: begin
                if (r_i < r_count && rd_free) begin
                    c_wr        = 1'b1;
                    c_wr_idx    = r_idx;
                    c_wr_len_en = 1'b1;
                    c_wr_len    = r_slen + rd_len;
                    c_rm        = 1'b1;
                    c_rm_idx    = r_i[IW-1:0];
                    n_slen      = r_slen + rd_len;
                    n_count     = r_count - 1'b1;
                end
                n_status = ST_OK;
                if (r_idx == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = CW'(r_idx - 1'b1);
                    n_state = S_FPREV;
                end
            end

            // merge into the preceding segment
            S_FPREV: begin
                if (rd_free) begin
                    c_wr        = 1'b1;
                    c_wr_idx    = r_i[IW-1:0];
                    c_wr_len_en = 1'b1;
                    c_wr_len    = rd_len + r_slen;
                    c_rm        = 1'b1;
                    c_rm_idx    = r_idx;
                    n_count     = r_count - 1'b1;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CW'(1);
            r_rover <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rover <= n_rover;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_n      <= n_n;
        r_first  <= n_first;
        r_idx    <= n_idx;
        r_slen   <= n_slen;
        r_sstart <= n_sstart;
        r_found  <= n_found;
        r_size   <= n_size;
        r_addr   <= n_addr;
        r_mode   <= n_mode;
        r_status <= n_status;
        r_raddr  <= n_raddr;
    end

    // per-entry update: split shifts up, remove shifts down
    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_ent
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == MAX_SEGMENTS - 1) ? g : g + 1;
        localparam logic [CW-1:0] GI = CW'(g);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                if (g == 0) begin
                    r_start[g] <= '0;
                    r_len[g]   <= LW'(MEM_UNITS);
                    r_free[g]  <= 1'b1;
                end
            end else begin
                if (c_split) begin
                    if (GI == CW'(r_idx)) begin
                        r_len[g]  <= r_size;
                        r_free[g] <= 1'b0;
                    end else if (GI == CW'(r_idx) + 1'b1) begin
                        r_start[g] <= w_split_start;
                        r_len[g]   <= w_split_len;
                        r_free[g]  <= 1'b1;
                    end else if (GI > CW'(r_idx) + 1'b1) begin
                        r_start[g] <= r_start[PREV];
                        r_len[g]   <= r_len[PREV];
                        r_free[g]  <= r_free[PREV];
                    end
                end
                if (c_rm && GI >= CW'(c_rm_idx)) begin
                    r_start[g] <= r_start[NEXT];
                    r_len[g]   <= r_len[NEXT];
                    r_free[g]  <= r_free[NEXT];
                end
                if (c_wr && GI == CW'(c_wr_idx)) begin
                    if (c_wr_len_en) begin
                        r_len[g] <= c_wr_len;
                    end
                    if (c_wr_free_en) begin
                        r_free[g] <= c_wr_free;
                    end
                end
            end
        end
    end

endmodule

// ----- bench/variable_partition_allocator_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator_checker
// Tracks the segment table alongside the allocator, predicts one result per
// accepted request and compares each popped result with the oldest one.
// ----------------------------------------------------------------------------
module variable_partition_allocator_checker import vpa_pkg::*; #(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  t_req       i_req,
    input  logic       i_empty,
    input  logic       i_pop,
    input  t_res       i_res,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_data,
    output int         o_pending,
    output int         o_errors
);

    logic [AW-1:0] seg_base [MAX_SEGMENTS];
    logic [LW-1:0] seg_len  [MAX_SEGMENTS];
    bit            seg_open [MAX_SEGMENTS];
    int            seg_count;
    logic [AW-1:0] rover;
    logic [1:0]    policy;
    t_res          expected_results[$];

    function automatic void drop_segment(int idx);
        for (int k = idx; k + 1 < seg_count; k++) begin
            seg_base[k] = seg_base[k+1];
            seg_len[k]  = seg_len[k+1];
            seg_open[k] = seg_open[k+1];
        end
        seg_count--;
    endfunction

    function automatic int pick_segment(logic [LW-1:0] size);
        int found;
        int idx;
        found = seg_count;
        if (policy == MODE_BEST) begin
            for (int i = 0; i < seg_count; i++)
                if (seg_open[i] && seg_len[i] >= size &&
                    (found == seg_count || seg_len[i] < seg_len[found]))
                    found = i;
        end else if (policy == MODE_NEXT) begin
            idx = 0;
            for (int i = 0; i < seg_count; i++)
                if (seg_base[i] <= rover) idx = i;
            for (int n = 0; n < seg_count; n++) begin
                if (seg_open[idx] && seg_len[idx] >= size) return idx;
                idx = (idx + 1 >= seg_count) ? 0 : idx + 1;
            end
        end else begin
            for (int i = 0; i < seg_count; i++)
                if (seg_open[i] && seg_len[i] >= size) return i;
        end
        return found;
    endfunction

    function automatic t_res serve_request(t_req r);
        t_res res;
        int   idx;
        res = '0;
        if (r.op == OP_ALLOC) begin
            if (r.alloc_size == 0) begin
                res.status = ST_ZERO;
                return res;
            end
            idx = pick_segment(r.alloc_size);
            if (idx >= seg_count) begin
                res.status = ST_NO_FIT;
                return res;
            end
            if (seg_len[idx] > r.alloc_size) begin
                if (seg_count >= MAX_SEGMENTS) begin
                    res.status = ST_FULL;
                    return res;
                end
                for (int k = seg_count; k > idx + 1; k--) begin
                    seg_base[k] = seg_base[k-1];
                    seg_len[k]  = seg_len[k-1];
                    seg_open[k] = seg_open[k-1];
                end
                seg_base[idx+1] = AW'(seg_base[idx] + r.alloc_size);
                seg_len[idx+1]  = seg_len[idx] - r.alloc_size;
                seg_open[idx+1] = 1'b1;
                seg_len[idx]    = r.alloc_size;
                seg_count++;
            end
            seg_open[idx] = 1'b0;
            if (policy == MODE_NEXT)
                rover = (idx + 1 < seg_count) ? seg_base[idx+1] : '0;
            res.status        = ST_OK;
            res.block_address = seg_base[idx];
            return res;
        end
        for (int i = 0; i < seg_count; i++) begin
            if (seg_base[i] == r.free_address) begin
                seg_open[i] = 1'b1;
                if (i + 1 < seg_count && seg_open[i+1]) begin
                    seg_len[i] += seg_len[i+1];
                    drop_segment(i + 1);
                end
                if (i > 0 && seg_open[i-1]) begin
                    seg_len[i-1] += seg_len[i];
                    drop_segment(i);
                end
                res.status = ST_OK;
                return res;
            end
        end
        res.status = ST_NO_SEGMENT;
        return res;
    endfunction

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            seg_base[0] = '0;
            seg_len[0]  = LW'(MEM_UNITS);
            seg_open[0] = 1'b1;
            seg_count   = 1;
            rover       = '0;
            policy      = MODE_FIRST;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) policy = i_cfg_data;
            if (i_push && !i_full) expected_results.push_back(serve_request(i_req));
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat status=%0d addr=%0d",
                             $time, i_res.status, i_res.block_address);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== i_res.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_res.status);
                        o_errors++;
                    end
                    if (want.block_address !== i_res.block_address) begin
                        $display("%0t: block_address expected %0d actual %0d",
                                 $time, want.block_address, i_res.block_address);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- bench/variable_partition_allocator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator_core_test
// Drives allocate/free requests under every fit mode with bursty pushes and
// stalling pops; the checker beside the core predicts and compares results.
// ----------------------------------------------------------------------------
module variable_partition_allocator_core_test;
    import vpa_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 80;     // longer than the worst table walk
    localparam int PHASE_ITEMS  = 110;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    t_req       i_req;
    logic       full;
    logic       empty;
    logic       pop;
    t_res       o_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data;

    int pending;
    int errors;
    int cycles;

    // receiver side: stall pattern plus an on-demand long hold-off
    int  hold_left;
    bit  hold_request;
    int  pop_style;

    // addresses handed out, reused to build meaningful frees
    logic [AW-1:0] live_blocks[$];
    int            status_seen[5];
    int            items_sent;

    variable_partition_allocator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_req       (i_req),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    variable_partition_allocator_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_req       (i_req),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Pop pattern is picked at random among: always ready, ~half, ~quarter.
    // A requested hold-off keeps pop low long enough for the input queue to fill.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 400;
        end
        if (cycles % 300 == 0) pop_style = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (pop_style == 0) begin
            pop <= 1'b1;
        end else if (pop_style == 1) begin
            pop <= ($urandom_range(0, 1) == 1);
        end else begin
            pop <= ($urandom_range(0, 3) == 0);
        end
    end

    // Remember successful allocations so frees hit real segment starts.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (o_res.status <= ST_ZERO) status_seen[o_res.status]++;
            if (o_res.status == ST_OK && o_res.block_address != 0 && live_blocks.size() < 64)
                live_blocks.push_back(o_res.block_address);
        end
    end

    // One request beat; push stays high on return so back-to-back beats need
    // no extra NBA.
    task automatic send(input logic op, input int size, input int addr);
        push               <= 1'b1;
        i_req.op           <= op;
        i_req.alloc_size   <= LW'(size);
        i_req.free_address <= AW'(addr);
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    task automatic pause(input int n);
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Sender pause until every expected result is back, then the walk latency.
    task automatic drain();
        pause(1);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_fit_mode(input logic [1:0] mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small allocations and frees of known blocks: this fills the table
    // and keeps it fragmented. The rest is noise: big/odd sizes, stray addresses.
    task automatic send_random();
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            send(OP_ALLOC, $urandom_range(1, 48), $urandom_range(0, 1023));
        end else if (pick < 52) begin
            send(OP_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 1023));
        end else if (pick < 56) begin
            send(OP_ALLOC, $urandom_range(200, 1024), $urandom_range(0, 1023));
        end else if (pick < 58) begin
            send(OP_ALLOC, 0, $urandom_range(0, 1023));
        end else if (pick < 90 && live_blocks.size() > 0) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            send(OP_FREE, $urandom_range(0, 2047), live_blocks[idx]);
            live_blocks.delete(idx);
        end else begin
            send(OP_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
        end
    endtask

    task automatic random_phase(input int count);
        int burst;
        int done;
        done = 0;
        while (done < count) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && done < count; k++) begin
                send_random();
                done++;
            end
            if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
        end
    endtask

    initial begin
        logic [1:0] modes[8];
        push         = 1'b0;
        i_req        = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        pop          = 1'b0;
        hold_left    = 0;
        hold_request = 1'b0;
        pop_style    = 0;
        cycles       = 0;
        items_sent   = 0;
        modes        = '{MODE_FIRST, MODE_BEST, MODE_NEXT, 2'd3,
                         MODE_NEXT, MODE_BEST, MODE_FIRST, MODE_NEXT};
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, zero size, oversize, whole region,
        // double free, unknown address, merges on both sides.
        send(OP_ALLOC, 0, 0);
        send(OP_ALLOC, 2047, 1023);
        send(OP_ALLOC, 1025, 0);
        send(OP_ALLOC, 1024, 0);
        send(OP_ALLOC, 1, 0);
        send(OP_FREE, 0, 0);
        send(OP_FREE, 2047, 0);
        send(OP_FREE, 0, 1023);
        send(OP_ALLOC, 1, 0);
        send(OP_ALLOC, 1022, 0);
        send(OP_ALLOC, 1, 0);
        send(OP_FREE, 0, 1);
        send(OP_FREE, 0, 1023);
        send(OP_FREE, 0, 0);
        drain();
        set_fit_mode(MODE_BEST);
        send(OP_ALLOC, 100, 0);
        send(OP_ALLOC, 50, 0);
        send(OP_ALLOC, 200, 0);
        send(OP_FREE, 0, 0);
        send(OP_FREE, 0, 150);
        send(OP_ALLOC, 40, 0);
        drain();
        set_fit_mode(MODE_NEXT);
        send(OP_ALLOC, 10, 0);
        send(OP_ALLOC, 10, 0);
        send(OP_ALLOC, 1024, 0);

        // Long receiver hold-off while the sender keeps offering beats.
        hold_request = 1'b1;
        for (int k = 0; k < 12; k++) send_random();
        drain();

        foreach (modes[m]) begin
            set_fit_mode(modes[m]);
            random_phase(PHASE_ITEMS);
            drain();
        end

        $display("Sent %0d requests across first/best/next/unused fit modes.", items_sent);
        $display("Statuses seen: ok %0d, no-fit %0d, no-segment %0d, full %0d, zero %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
